// ===== rtl/ico_pkg.sv =====
// ico_pkg: shared constants and types for the internet checksum offload block.
// Used by ico_front, ico_fifo, ico_back, ico_checker and the top level; no dependencies.
package ico_pkg;

    // Bytes at and past this index are not summed; packet length saturates here.
    localparam logic [16:0] MAX_PACKET_BYTES = 17'd65535;
    // Byte counter saturation value.
    localparam logic [16:0] COUNT_MAX = 17'h1ffff;

    // Depth of the packet queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Status codes.
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_START_RANGE = 2'd1;
    localparam logic [1:0] ST_FIELD_RANGE = 2'd2;

    localparam logic [15:0] CSUM_ALL_ONES = 16'hffff;

    // One finished packet, handed from front to back.
    typedef struct packed {
        logic [31:0] sum;
        logic [15:0] plen;
        logic [15:0] start;
        logic [15:0] field;
        logic        udp;
    } ico_rec_t;

    // Push request from front into the queue.
    typedef struct packed {
        logic     valid;
        ico_rec_t rec;
    } ico_push_t;

endpackage

// ===== rtl/ico_front.sv =====
// ico_front: takes packet bytes, latches per-packet settings, accumulates the
// 16-bit word sum and byte count, pushes a record on the last byte. Uses ico_pkg.
module ico_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  logic [15:0]       start_offset,
    input  logic [15:0]       field_offset,
    input  logic              udp_mode,
    output ico_pkg::ico_push_t push
);

    logic [31:0] sum_reg, sum_next;
    logic [16:0] cnt_reg, cnt_next;
    logic [15:0] start_reg, field_reg;
    logic        udp_reg;

    logic        first;
    logic [15:0] start_eff, field_eff;
    logic        udp_eff;
    logic        in_range, odd;
    logic [15:0] addend;
    logic [31:0] sum_base, sum_acc;
    logic [16:0] cnt_inc;

    always_comb begin
        first     = (cnt_reg == 17'd0);
        start_eff = first ? start_offset : start_reg;
        field_eff = first ? field_offset : field_reg;
        udp_eff   = first ? udp_mode : udp_reg;
        in_range  = (cnt_reg >= {1'b0, start_eff}) && (cnt_reg < ico_pkg::MAX_PACKET_BYTES);
        // parity relative to start picks the high or low half of the word
        odd       = cnt_reg[0] ^ start_eff[0];
        if (!in_range) begin
            addend = 16'd0;
        end else if (odd) begin
            addend = {8'd0, data_byte};
        end else begin
            addend = {data_byte, 8'd0};
        end
        sum_base = first ? 32'd0 : sum_reg;
        sum_acc  = sum_base + {16'd0, addend};
        cnt_inc  = (cnt_reg == ico_pkg::COUNT_MAX) ? cnt_reg : cnt_reg + 17'd1;

        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (in_fire) begin
            if (last_byte) begin
                sum_next = 32'd0;
                cnt_next = 17'd0;
            end else begin
                sum_next = sum_acc;
                cnt_next = cnt_inc;
            end
        end

        push.valid     = in_fire && last_byte;
        push.rec.sum   = sum_acc;
        push.rec.plen  = (cnt_inc >= ico_pkg::MAX_PACKET_BYTES) ?
                         ico_pkg::MAX_PACKET_BYTES[15:0] : cnt_inc[15:0];
        push.rec.start = start_eff;
        push.rec.field = field_eff;
        push.rec.udp   = udp_eff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= 32'd0;
            cnt_reg   <= 17'd0;
            start_reg <= 16'd0;
            field_reg <= 16'd0;
            udp_reg   <= 1'b0;
        end else begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
            if (in_fire) begin
                start_reg <= start_eff;
                field_reg <= field_eff;
                udp_reg   <= udp_eff;
            end
        end
    end

endmodule

// ===== rtl/ico_fifo.sv =====
// ico_fifo: short queue of finished-packet records between front and back.
// Uses ico_pkg for the record type and depth.
module ico_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  ico_pkg::ico_push_t push,
    input  logic              pop,
    output logic              full,
    output logic              empty,
    output ico_pkg::ico_rec_t head
);

    ico_pkg::ico_rec_t mem [ico_pkg::QDEPTH];

    logic [ico_pkg::QPTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [ico_pkg::QCNT_W-1:0] cnt_reg, cnt_next;
    logic do_push, do_pop;

    function automatic logic [ico_pkg::QPTR_W-1:0] ptr_inc(
        input logic [ico_pkg::QPTR_W-1:0] p
    );
        if (p == ico_pkg::QPTR_W'(ico_pkg::QDEPTH - 1)) begin
            return '0;
        end
        return p + ico_pkg::QPTR_W'(1);
    endfunction

    always_comb begin
        full     = (cnt_reg == ico_pkg::QCNT_W'(ico_pkg::QDEPTH));
        empty    = (cnt_reg == '0);
        do_push  = push.valid && !full;
        do_pop   = pop && !empty;
        wr_next  = do_push ? ptr_inc(wr_reg) : wr_reg;
        rd_next  = do_pop ? ptr_inc(rd_reg) : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + ico_pkg::QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - ico_pkg::QCNT_W'(1);
        end
        head = mem[rd_reg];
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_reg] <= push.rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/ico_back.sv =====
// ico_back: folds the sum, applies range checks and the UDP zero rule, and
// holds the result in the output register. Uses ico_pkg.
module ico_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  ico_pkg::ico_rec_t rec,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [15:0]       checksum,
    output logic [15:0]       field_position,
    output logic [1:0]        status
);

    logic        valid_reg;
    logic [15:0] csum_reg, pos_reg, csum_next, pos_next;
    logic [1:0]  status_reg, status_next;

    logic [16:0] fold1;
    logic [15:0] fold2, inv;
    logic [16:0] pos_full;
    logic [17:0] pos_end;

    always_comb begin
        // two end-around-carry steps reduce a 32-bit sum to 16 bits
        fold1    = {1'b0, rec.sum[15:0]} + {1'b0, rec.sum[31:16]};
        fold2    = fold1[15:0] + {15'd0, fold1[16]};
        inv      = ~fold2;
        pos_full = {1'b0, rec.start} + {1'b0, rec.field};
        pos_end  = {1'b0, pos_full} + 18'd2;

        csum_next   = 16'd0;
        pos_next    = 16'd0;
        status_next = ico_pkg::ST_OK;
        if (rec.start >= rec.plen) begin
            status_next = ico_pkg::ST_START_RANGE;
        end else if (pos_end > {2'b00, rec.plen}) begin
            status_next = ico_pkg::ST_FIELD_RANGE;
        end else begin
            pos_next  = pos_full[15:0];
            csum_next = (rec.udp && inv == 16'd0) ? ico_pkg::CSUM_ALL_ONES : inv;
        end

        pop = !q_empty && (!valid_reg || out_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            csum_reg   <= csum_next;
            pos_reg    <= pos_next;
            status_reg <= status_next;
        end
    end

    assign out_valid      = valid_reg;
    assign checksum       = csum_reg;
    assign field_position = pos_reg;
    assign status         = status_reg;

endmodule

// ===== rtl/internet_checksum_offload_top.sv =====
// internet_checksum_offload_top: RFC 1071 checksum offload engine, top level.
// Instantiates ico_front, ico_fifo and ico_back; uses ico_pkg.
//
// Usage:
//   Slave channel (s_*): one packet byte per request. s_tlast marks the final
//   byte. The first byte of a packet also carries the start offset, the
//   checksum field offset (relative to start) and the UDP flag; these are
//   ignored on later bytes.
//   Master channel (m_*): one request per packet, after its last byte: the
//   inverted folded checksum (high byte goes first on the wire), the absolute
//   field position, and a status (0 ok, 1 start beyond packet, 2 field beyond
//   packet; checksum and position read 0 when status is nonzero).
//   Throughput: one byte per cycle while s_tready is high, including
//   back-to-back one-byte packets. The result of a packet passes through
//   the packet queue and then the output register before m_tvalid rises.
//   Stall: while m_tready is low the result holds; bytes keep flowing until
//   the two-entry packet queue fills, then s_tready drops.
//   Reset (aresetn low, synchronous): the byte count, sum, queue and output
//   valid are cleared; the next byte is the first of a new packet.
module internet_checksum_offload_top (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [7:0] data_byte, [23:8] start_offset, [39:24] field_offset
    input  logic [39:0] s_tdata,
    // s_tuser: [0] udp_mode
    input  logic        s_tuser,
    input  logic        s_tlast,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata: [15:0] checksum, [31:16] field_position
    output logic [31:0] m_tdata,
    // m_tuser: [1:0] status
    output logic [1:0]  m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready
);

    ico_pkg::ico_push_t push;
    ico_pkg::ico_rec_t  head;
    logic q_full, q_empty, pop, in_fire;
    logic [15:0] checksum, field_position;

    // Front stalls only when the packet queue is full.
    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;

    ico_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_fire      (in_fire),
        .data_byte    (s_tdata[7:0]),
        .last_byte    (s_tlast),
        .start_offset (s_tdata[23:8]),
        .field_offset (s_tdata[39:24]),
        .udp_mode     (s_tuser),
        .push         (push)
    );

    ico_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .full    (q_full),
        .empty   (q_empty),
        .head    (head)
    );

    ico_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_empty        (q_empty),
        .rec            (head),
        .pop            (pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .checksum       (checksum),
        .field_position (field_position),
        .status         (m_tuser)
    );

    assign m_tdata = {field_position, checksum};

endmodule

// ===== rtl/ico_checker.sv =====
// ico_checker: port-level assertions for internet_checksum_offload_top, bound
// to the top level below. Uses ico_pkg status codes.
module ico_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tvalid,
    input logic        m_tready
);

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Only defined status codes appear.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ico_pkg::ST_OK || m_tuser == ico_pkg::ST_START_RANGE
                      || m_tuser == ico_pkg::ST_FIELD_RANGE))
        else $error("undefined status code");

    // Range errors carry a zero checksum and position.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ico_pkg::ST_OK |-> m_tdata == 32'd0)
        else $error("nonzero payload on range error");

    // No result right after reset.
    a_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind internet_checksum_offload_top ico_checker u_ico_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
